>>> hdl/dcsm_pkg.sv
// Package for the geared DC servo motor model step unit.
// Command codes, controller states, command/status structs. No dependencies.
package dcsm_pkg;

  localparam int unsigned DW = 32;

  typedef enum logic [1:0] {
    CMD_VOLT   = 2'd0,
    CMD_TORQUE = 2'd1,
    CMD_STEP   = 2'd2,
    CMD_INIT   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_KT   = 3'd0,
    REG_RES  = 3'd1,
    REG_N    = 3'd2,
    REG_EFF  = 3'd3,
    REG_VSUP = 3'd4,
    REG_J    = 3'd5,
    REG_KP   = 3'd6,
    REG_KD   = 3'd7
  } reg_idx_t;

  // Datapath micro-operations.
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2,
    OP_ADD  = 2'd3
  } op_t;

  // Operand selectors.
  typedef enum logic [4:0] {
    SRC_ACC  = 5'd0,
    SRC_NK   = 5'd1,
    SRC_VAL  = 5'd2,
    SRC_RATE = 5'd3,
    SRC_RES  = 5'd4,
    SRC_TMP  = 5'd5,
    SRC_VC   = 5'd6,
    SRC_KT   = 5'd7,
    SRC_N    = 5'd8,
    SRC_EP   = 5'd9,
    SRC_EV   = 5'd10,
    SRC_KP   = 5'd11,
    SRC_KD   = 5'd12,
    SRC_DT   = 5'd13,
    SRC_J    = 5'd14,
    SRC_EFF  = 5'd15,
    SRC_ANG  = 5'd16,
    SRC_POS  = 5'd17,
    SRC_VEL  = 5'd18
  } src_t;

  typedef enum logic [3:0] {
    DST_ACC = 4'd0,
    DST_NK  = 4'd1,
    DST_TMP = 4'd2,
    DST_C   = 4'd3,
    DST_VEL = 4'd4,
    DST_POS = 4'd5,
    DST_VLT = 4'd6,
    DST_EP  = 4'd7,
    DST_EV  = 4'd8
  } dst_t;

  typedef enum logic [4:0] {
    S_IDLE, S_NK, S_T1, S_T2, S_T3, S_T4, S_T5,
    S_S1, S_S2, S_S3, S_S4, S_S5, S_S6,
    S_D1, S_D2, S_D3, S_D4, S_D5, S_D6, S_D7, S_D8, S_D9, S_D10, S_D11,
    S_EFF, S_OUT
  } state_t;

  typedef struct packed {
    logic  start;     // latch inputs, clear flag
    logic  go;        // launch an operation
    op_t   op;
    src_t  src_a;
    src_t  src_b;
    logic  neg_b;     // subtract for OP_ADD
    dst_t  dst;
    logic  clip;      // form clipped voltage into c
    logic  set_volt;  // stored voltage <= command value
    logic  init_disc;
    logic  zero_acc;
  } dcsm_cmd_t;

  typedef struct packed {
    logic busy;
  } dcsm_sts_t;

endpackage

>>> hdl/dcsm_datapath.sv
// Datapath: config registers, state, shared rounding multiplier and
// bit-serial rounding divider with 32-bit saturation. Uses dcsm_pkg.
module dcsm_datapath import dcsm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  input  logic [1:0]       in_cmd,
  input  logic [31:0]      in_val,
  input  logic [31:0]      in_angle,
  input  logic [31:0]      in_rate,
  input  logic [30:0]      in_dt,
  input  dcsm_cmd_t        cmd,
  output dcsm_sts_t        sts,
  output logic [1:0]       cmd_code,
  output logic             j_pos,
  output logic [31:0]      acc,
  output logic [31:0]      volt,
  output logic             sat_flag
);

  localparam int DIVW = 32 + FRAC_BITS + 1;

  logic [30:0] kt_r, res_r, n_r, vsup_r, j_r;
  logic [16:0] eff_r;
  logic signed [31:0] kp_r, kd_r;
  logic signed [31:0] volt_r, pos_r, vel_r;
  logic signed [31:0] acc_r, nk_r, tmp_r, c_r, ep_r, ev_r;
  logic [1:0]  cmd_r;
  logic signed [31:0] val_r, angle_r, rate_r;
  logic [30:0] dt_r;
  logic        sat_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kt_r   <= 31'(((64'd992 << FRAC_BITS) + 64'd50000) / 64'd100000);
      res_r  <= 31'(64'd19 << (FRAC_BITS - 1));
      n_r    <= 31'(64'd193 << FRAC_BITS);
      eff_r  <= 17'(64'd1 << FRAC_BITS);
      vsup_r <= 31'(((64'd136 << FRAC_BITS) + 64'd5) / 64'd10);
      j_r    <= '0;
      kp_r   <= '0;
      kd_r   <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_KT:   kt_r   <= cfg_data[30:0];
        REG_RES:  res_r  <= cfg_data[30:0];
        REG_N:    n_r    <= cfg_data[30:0];
        REG_EFF:  eff_r  <= cfg_data[16:0];
        REG_VSUP: vsup_r <= cfg_data[30:0];
        REG_J:    j_r    <= cfg_data[30:0];
        REG_KP:   kp_r   <= cfg_data;
        REG_KD:   kd_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operand select
  function automatic logic signed [32:0] pick(input src_t s,
      input logic signed [31:0] a, nk, v, r, t, vc, ep, ev, ang, pos, vel,
      input logic [30:0] kt, res, n, dt, j, input logic [16:0] eff,
      input logic signed [31:0] kp, kd);
    logic signed [32:0] o;
    begin
      o = '0;
      unique case (s)
        SRC_ACC:  o = 33'(a);
        SRC_NK:   o = 33'(nk);
        SRC_VAL:  o = 33'(v);
        SRC_RATE: o = 33'(r);
        SRC_RES:  o = {2'b00, res};
        SRC_TMP:  o = 33'(t);
        SRC_VC:   o = 33'(vc);
        SRC_KT:   o = {2'b00, kt};
        SRC_N:    o = {2'b00, n};
        SRC_EP:   o = 33'(ep);
        SRC_EV:   o = 33'(ev);
        SRC_KP:   o = 33'(kp);
        SRC_KD:   o = 33'(kd);
        SRC_DT:   o = {2'b00, dt};
        SRC_J:    o = {2'b00, j};
        SRC_EFF:  o = {16'd0, eff};
        SRC_ANG:  o = 33'(ang);
        SRC_POS:  o = 33'(pos);
        SRC_VEL:  o = 33'(vel);
        default:  o = '0;
      endcase
      return o;
    end
  endfunction

  logic signed [32:0] opa, opb;
  always_comb begin
    opa = pick(cmd.src_a, acc_r, nk_r, val_r, rate_r, tmp_r, c_r, ep_r, ev_r,
               angle_r, pos_r, vel_r, kt_r, res_r, n_r, dt_r, j_r, eff_r, kp_r, kd_r);
    opb = pick(cmd.src_b, acc_r, nk_r, val_r, rate_r, tmp_r, c_r, ep_r, ev_r,
               angle_r, pos_r, vel_r, kt_r, res_r, n_r, dt_r, j_r, eff_r, kp_r, kd_r);
  end

  // Multiplier stage: registered product, then round/saturate
  logic signed [65:0] prod_r;
  logic [1:0]  mstage_r;
  logic        mneg;
  logic [65:0] mmag, mround;

  // Divider: restoring, one bit per cycle
  logic [DIVW-1:0] dq_r, drem_r;
  logic [31:0]     dd_r;
  logic [5:0]      dcnt_r;
  logic            dneg_r, dbusy_r, dzero_r, dnz_r, dsign_r;
  logic [DIVW:0]   dtrial;
  logic [DIVW:0]   dsh;

  // Result capture
  logic            wr;
  logic signed [31:0] res_v;
  logic            res_sat;
  logic            add_busy_r;
  logic signed [33:0] sum;
  logic signed [31:0] acc_add_a, acc_add_b;
  logic cmd_neg_r;
  dst_t dst_r;

  always_comb begin
    mneg   = prod_r[65];
    mmag   = mneg ? 66'(-prod_r) : 66'(prod_r);
    mround = (mmag + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    dsh    = {drem_r, dq_r[DIVW-1]};
    dtrial = dsh - {{(DIVW-31){1'b0}}, dd_r};
  end

  function automatic logic [32:0] from_mag(input logic neg, input logic [65:0] m);
    // returns {sat, value}
    begin
      if (neg) begin
        if (m > 66'h80000000) return {1'b1, 32'h80000000};
        return {1'b0, 32'(-m)};
      end
      if (m > 66'h7FFFFFFF) return {1'b1, 32'h7FFFFFFF};
      return {1'b0, m[31:0]};
    end
  endfunction

  logic [32:0] mres, dres;
  logic [65:0] dfin;
  always_comb begin
    mres = from_mag(mneg, mround);
    dfin = {{(66-DIVW){1'b0}}, dq_r} + 66'(dnz_r);
    if (dzero_r)
      dres = dsign_r ? 33'h0 : from_mag(dneg_r, 66'hFFFFFFFF) | 33'h100000000;
    else
      dres = from_mag(dneg_r, dfin);
    sum = 34'(acc_add_a) + (cmd_neg_r ? -34'(acc_add_b) : 34'(acc_add_b));
  end

  logic busy;
  assign busy = (mstage_r != 2'd0) || dbusy_r || add_busy_r;
  assign sts.busy = busy || cmd.go;

  always_comb begin
    wr = 1'b0;
    res_v = '0;
    res_sat = 1'b0;
    if (mstage_r == 2'd2) begin
      wr = 1'b1; res_v = mres[31:0]; res_sat = mres[32];
    end else if (dbusy_r && dcnt_r == 6'd0) begin
      wr = 1'b1; res_v = dres[31:0]; res_sat = dres[32];
    end else if (add_busy_r) begin
      wr = 1'b1;
      if (sum > 34'sh7FFFFFFF) begin res_v = 32'h7FFFFFFF; res_sat = 1'b1; end
      else if (sum < -34'sh80000000) begin res_v = 32'h80000000; res_sat = 1'b1; end
      else res_v = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mstage_r   <= '0;
      dbusy_r    <= 1'b0;
      add_busy_r <= 1'b0;
      volt_r     <= '0;
      pos_r      <= '0;
      vel_r      <= '0;
      sat_r      <= 1'b0;
    end else begin
      if (cmd.start) begin
        cmd_r   <= in_cmd;
        val_r   <= in_val;
        angle_r <= in_angle;
        rate_r  <= in_rate;
        dt_r    <= in_dt;
        sat_r   <= 1'b0;
      end
      if (cmd.set_volt) volt_r <= val_r;
      if (cmd.init_disc) begin
        pos_r <= angle_r;
        vel_r <= rate_r;
      end
      if (cmd.zero_acc) acc_r <= '0;
      // voltage clip into c_r register slot as vc
      if (cmd.clip) begin
        if (33'(volt_r) > $signed({2'b00, vsup_r})) c_r <= {1'b0, vsup_r};
        else if (33'(volt_r) < -$signed({2'b00, vsup_r})) c_r <= -{1'b0, vsup_r};
        else c_r <= volt_r;
      end
      if (cmd.go) begin
        dst_r     <= cmd.dst;
        cmd_neg_r <= cmd.neg_b;
        unique case (cmd.op)
          OP_MUL: begin
            prod_r   <= 66'(opa) * 66'(opb);
            mstage_r <= 2'd1;
          end
          OP_DIV: begin
            dneg_r  <= opa[32] != opb[32];
            dsign_r <= (opa == 33'sd0);
            dzero_r <= (opb == 33'sd0);
            dq_r    <= DIVW'((opa[32] ? 33'(-opa) : opa)) << FRAC_BITS;
            drem_r  <= '0;
            dd_r    <= opb[32] ? 32'(-opb) : opb[31:0];
            dcnt_r  <= 6'(DIVW);
            dnz_r   <= 1'b0;
            dbusy_r <= 1'b1;
          end
          OP_ADD: begin
            acc_add_a  <= opa[31:0];
            acc_add_b  <= opb[31:0];
            add_busy_r <= 1'b1;
          end
          default: ;
        endcase
      end else begin
        if (mstage_r == 2'd1) mstage_r <= 2'd2;
        else if (mstage_r == 2'd2) mstage_r <= 2'd0;
        add_busy_r <= 1'b0;
        if (dbusy_r) begin
          if (dcnt_r == 6'd0) dbusy_r <= 1'b0;
          else begin
            dcnt_r <= dcnt_r - 6'd1;
            if (!dtrial[DIVW]) begin
              drem_r <= dtrial[DIVW-1:0];
              dq_r   <= {dq_r[DIVW-2:0], 1'b1};
            end else begin
              drem_r <= dsh[DIVW-1:0];
              dq_r   <= {dq_r[DIVW-2:0], 1'b0};
            end
            // round bit: remainder*2 >= d at end
            if (dcnt_r == 6'd1)
              dnz_r <= ({(!dtrial[DIVW] ? dtrial[DIVW-1:0] : dsh[DIVW-1:0]), 1'b0}
                        >= {{(DIVW-31){1'b0}}, dd_r});
          end
        end
      end
      if (wr) begin
        if (res_sat) sat_r <= 1'b1;
        unique case (dst_r)
          DST_ACC: acc_r  <= res_v;
          DST_NK:  nk_r   <= res_v;
          DST_TMP: tmp_r  <= res_v;
          DST_C:   c_r    <= res_v;
          DST_VEL: vel_r  <= res_v;
          DST_POS: pos_r  <= res_v;
          DST_VLT: volt_r <= res_v;
          DST_EP:  ep_r   <= res_v;
          DST_EV:  ev_r   <= res_v;
          default: ;
        endcase
      end
    end
  end

  assign cmd_code = cmd_r;
  assign j_pos    = (j_r != '0);
  assign acc      = acc_r;
  assign volt     = volt_r;
  assign sat_flag = sat_r;

endmodule

>>> hdl/dcsm_ctrl.sv
// Controller: sequences micro-operations over the datapath per command.
// Uses dcsm_pkg command/status structs and state enum.
module dcsm_ctrl import dcsm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] cmd_code,
  input  logic       j_pos,
  input  dcsm_sts_t  sts,
  output dcsm_cmd_t  cmd,
  output logic       out_load
);

  state_t state_r, state_nxt;
  logic   issued_r, issued_nxt;
  logic   ovalid_r, ovalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issued_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // At most one operation per state: issue, wait for done, advance.
  always_comb begin
    logic   done;
    state_t after;
    cmd        = '0;
    state_nxt  = state_r;
    issued_nxt = issued_r;
    after      = S_IDLE;
    out_load   = 1'b0;
    ovalid_nxt = ovalid_r && out_stall;
    in_stall   = (state_r != S_IDLE);
    done       = issued_r && !sts.busy;
    unique case (state_r)
      S_IDLE:  begin
        if (in_valid) begin
          cmd.start = 1'b1; state_nxt = S_NK;
        end
      end
      S_NK:  begin
        cmd.op = OP_MUL; cmd.src_a = SRC_N; cmd.src_b = SRC_KT; cmd.dst = DST_NK;
        cmd.zero_acc = 1'b1;
        unique case (cmd_t'(cmd_code))
          CMD_VOLT:   after = S_OUT;
          CMD_TORQUE: after = S_T1;
          CMD_STEP:   after = S_S1;
          CMD_INIT:   after = S_OUT;
          default:    after = S_OUT;
        endcase
      end
      S_T1: begin cmd.op = OP_MUL; cmd.src_a = SRC_VAL; cmd.src_b = SRC_RES;
        cmd.dst = DST_TMP; after = S_T2; end
      S_T2: begin cmd.op = OP_DIV; cmd.src_a = SRC_TMP; cmd.src_b = SRC_NK;
        cmd.dst = DST_TMP; after = S_T3; end
      S_T3: begin cmd.op = OP_MUL; cmd.src_a = SRC_NK; cmd.src_b = SRC_RATE;
        cmd.dst = DST_ACC; after = S_T4; end
      S_T4: begin cmd.op = OP_ADD; cmd.src_a = SRC_TMP; cmd.src_b = SRC_ACC;
        cmd.dst = DST_VLT; after = S_T5; end
      S_T5: begin cmd.zero_acc = 1'b1; state_nxt = S_OUT; end
      S_S1: begin cmd.op = OP_MUL; cmd.src_a = SRC_NK; cmd.src_b = SRC_RATE;
        cmd.dst = DST_TMP; cmd.clip = !issued_r; after = S_S2; end
      S_S2: begin cmd.op = OP_ADD; cmd.src_a = SRC_VC; cmd.src_b = SRC_TMP;
        cmd.neg_b = 1'b1; cmd.dst = DST_ACC; after = S_S3; end
      S_S3: begin cmd.op = OP_MUL; cmd.src_a = SRC_NK; cmd.src_b = SRC_ACC;
        cmd.dst = DST_ACC; after = S_S4; end
      S_S4: begin cmd.op = OP_DIV; cmd.src_a = SRC_ACC; cmd.src_b = SRC_RES;
        cmd.dst = DST_ACC; after = j_pos ? S_D1 : S_EFF; end
      // ep = angle - pos, ev = rate - vel
      S_D1: begin cmd.op = OP_ADD; cmd.src_a = SRC_ANG; cmd.src_b = SRC_POS;
        cmd.neg_b = 1'b1; cmd.dst = DST_EP; after = S_D2; end
      S_D2: begin cmd.op = OP_ADD; cmd.src_a = SRC_RATE; cmd.src_b = SRC_VEL;
        cmd.neg_b = 1'b1; cmd.dst = DST_EV; after = S_D3; end
      // c = Kp*ep + Kd*ev, held in the vc slot
      S_D3: begin cmd.op = OP_MUL; cmd.src_a = SRC_KP; cmd.src_b = SRC_EP;
        cmd.dst = DST_TMP; after = S_D4; end
      S_D4: begin cmd.op = OP_MUL; cmd.src_a = SRC_KD; cmd.src_b = SRC_EV;
        cmd.dst = DST_C; after = S_D5; end
      S_D5: begin cmd.op = OP_ADD; cmd.src_a = SRC_TMP; cmd.src_b = SRC_VC;
        cmd.dst = DST_C; after = S_D6; end
      // vel += dt*c/J, then pos += dt*vel
      S_D6: begin cmd.op = OP_MUL; cmd.src_a = SRC_DT; cmd.src_b = SRC_VC;
        cmd.dst = DST_TMP; after = S_D7; end
      S_D7: begin cmd.op = OP_DIV; cmd.src_a = SRC_TMP; cmd.src_b = SRC_J;
        cmd.dst = DST_TMP; after = S_D8; end
      S_D8: begin cmd.op = OP_ADD; cmd.src_a = SRC_VEL; cmd.src_b = SRC_TMP;
        cmd.dst = DST_VEL; after = S_D9; end
      S_D9: begin cmd.op = OP_MUL; cmd.src_a = SRC_DT; cmd.src_b = SRC_VEL;
        cmd.dst = DST_TMP; after = S_D10; end
      S_D10: begin cmd.op = OP_ADD; cmd.src_a = SRC_POS; cmd.src_b = SRC_TMP;
        cmd.dst = DST_POS; after = S_D11; end
      // torque -= c
      S_D11: begin cmd.op = OP_ADD; cmd.src_a = SRC_ACC; cmd.src_b = SRC_VC;
        cmd.neg_b = 1'b1; cmd.dst = DST_ACC; after = S_EFF; end
      S_EFF: begin cmd.op = OP_MUL; cmd.src_a = SRC_ACC; cmd.src_b = SRC_EFF;
        cmd.dst = DST_ACC; after = S_OUT; end
      S_OUT: begin
        if (!ovalid_r || !out_stall) begin
          out_load   = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
          if (cmd_t'(cmd_code) == CMD_VOLT) cmd.set_volt = 1'b1;
          if (cmd_t'(cmd_code) == CMD_INIT) cmd.init_disc = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // generic issue / wait handshake for operation states
    if (cmd.op != OP_NONE) begin
      if (!issued_r) begin
        cmd.go = 1'b1; issued_nxt = 1'b1;
      end else if (done) begin
        issued_nxt = 1'b0; state_nxt = after;
      end
    end
  end

  assign out_valid = ovalid_r;

endmodule

>>> hdl/dc_servo_motor_model_step_unit.sv
// Geared DC servo motor model step unit, Q(32-FRAC_BITS).FRAC_BITS.
// Throughput: one transaction at a time; input stalls until the result register is
// loaded, and loading waits while a held result is stalled by the receiver.
// Reset (rst_n low, synchronous) restores register defaults and zeroes the voltage,
// disc position and velocity, saturation flag and controller state, not the outputs.
module dc_servo_motor_model_step_unit import dcsm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_command_value,
  input  logic [31:0] in_joint_angle,
  input  logic [31:0] in_joint_rate,
  input  logic [30:0] in_step_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_applied_torque,
  output logic [31:0] out_drive_voltage,
  output logic        out_saturated
);

  dcsm_cmd_t  cmd;
  dcsm_sts_t  sts;
  logic [1:0] cmd_code;
  logic       j_pos, out_load, sat_flag;
  logic [31:0] acc, volt;
  logic [31:0] in_command_value_q;

  dcsm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .cmd_code, .j_pos, .sts, .cmd, .out_load
  );

  dcsm_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_cmd, .in_val(in_command_value), .in_angle(in_joint_angle),
    .in_rate(in_joint_rate), .in_dt(in_step_time),
    .cmd, .sts, .cmd_code, .j_pos, .acc, .volt, .sat_flag
  );

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_applied_torque <= (cmd_t'(cmd_code) == CMD_STEP) ? acc : '0;
      out_drive_voltage  <= (cmd_t'(cmd_code) == CMD_VOLT) ? in_command_value_q : volt;
      out_saturated      <= sat_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) in_command_value_q <= in_command_value;
  end

endmodule

>>> sim/dc_servo_motor_model_step_unit_test.sv
// Self-checking testbench for dc_servo_motor_model_step_unit.
// Holds a scoreboard class with a fixed-point motor predictor; depends on dcsm_pkg
// and the unit under test.
module dc_servo_motor_model_step_unit_test;
  import dcsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint S32MAX = 64'sd2147483647;
  localparam longint S32MIN = -64'sd2147483648;
  localparam int     DRAIN_CYCLES = 300;
  localparam int     HOLD_CYCLES = 600;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = CMD_VOLT;
  logic [31:0] in_command_value = '0;
  logic [31:0] in_joint_angle = '0;
  logic [31:0] in_joint_rate = '0;
  logic [30:0] in_step_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_applied_torque;
  logic [31:0] out_drive_voltage;
  logic        out_saturated;

  int mismatches = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  always #4 clk = ~clk;

  dc_servo_motor_model_step_unit u_dut (.*);

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  typedef struct {
    logic [31:0] torque;
    logic [31:0] volt;
    logic        sat;
  } motor_result_t;

  // Predicts each transaction's result and holds expectations in order.
  class motor_scoreboard;
    longint kt, res, ratio, eff, vsup, inertia, kp, kd;
    longint volt, pos, vel;
    bit sat;
    motor_result_t pending[$];

    function new();
      kt = 650; res = 622592; ratio = 12648448; eff = 65536; vsup = 891290;
      inertia = 0; kp = 0; kd = 0; volt = 0; pos = 0; vel = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] d);
      case (idx)
        REG_KT:   kt = longint'(d[30:0]);
        REG_RES:  res = longint'(d[30:0]);
        REG_N:    ratio = longint'(d[30:0]);
        REG_EFF:  eff = longint'(d[16:0]);
        REG_VSUP: vsup = longint'(d[30:0]);
        REG_J:    inertia = longint'(d[30:0]);
        REG_KP:   kp = longint'($signed(d));
        REG_KD:   kd = longint'($signed(d));
        default: ;
      endcase
    endfunction

    function longint clamp(longint x);
      if (x > S32MAX) begin sat = 1; return S32MAX; end
      if (x < S32MIN) begin sat = 1; return S32MIN; end
      return x;
    endfunction

    function longint from_mag(bit neg, longint m);
      if (neg) begin
        if (m > 64'sd2147483648) begin sat = 1; return S32MIN; end
        return -m;
      end
      if (m > S32MAX) begin sat = 1; return S32MAX; end
      return m;
    endfunction

    function longint qmul(longint a, longint b);
      longint p, m;
      p = a * b;
      m = ((p < 0 ? -p : p) + 64'sd32768) >>> 16;
      return from_mag(p < 0, m);
    endfunction

    // Rounded divide; a zero divisor gives the limit with the numerator's sign.
    function longint qdiv(longint a, longint b);
      longint n, d;
      n = (a < 0 ? -a : a) <<< 16;
      d = b < 0 ? -b : b;
      if (d == 0) begin
        if (n == 0) return 0;
        return from_mag(a < 0, 64'sd4294967295);
      end
      return from_mag((a < 0) != (b < 0), (n + d / 2) / d);
    endfunction

    function void note_input(cmd_t c, logic [31:0] v, logic [31:0] a, logic [31:0] r,
                             logic [30:0] dt);
      longint value, angle, rate, step, nk, torque, vc, ep, ev, corr, dv;
      motor_result_t e;
      value = longint'($signed(v));
      angle = longint'($signed(a));
      rate = longint'($signed(r));
      step = longint'(dt);
      torque = 0;
      sat = 0;
      nk = qmul(ratio, kt);
      case (c)
        CMD_VOLT: volt = value;
        CMD_TORQUE: volt = clamp(qdiv(qmul(value, res), nk) + qmul(nk, rate));
        CMD_INIT: begin
          pos = angle;
          vel = rate;
        end
        default: begin
          vc = volt;
          if (vc > vsup) vc = vsup;
          if (vc < -vsup) vc = -vsup;
          torque = clamp(vc - qmul(nk, rate));
          torque = qdiv(qmul(nk, torque), res);
          // virtual disc tracker, only with a positive inertia
          if (inertia > 0) begin
            ep = clamp(angle - pos);
            ev = clamp(rate - vel);
            corr = clamp(qmul(kp, ep) + qmul(kd, ev));
            dv = qdiv(qmul(step, corr), inertia);
            vel = clamp(vel + dv);
            pos = clamp(pos + qmul(step, vel));
            torque = clamp(torque - corr);
          end
          torque = qmul(torque, eff);
        end
      endcase
      e.torque = torque[31:0];
      e.volt = volt[31:0];
      e.sat = sat;
      pending.push_back(e);
    endfunction

    task check_result(logic [31:0] t, logic [31:0] v, logic s);
      motor_result_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", t, 32'h0);
        return;
      end
      e = pending.pop_front();
      if (t !== e.torque) report_mismatch("applied_torque", t, e.torque);
      if (v !== e.volt) report_mismatch("drive_voltage", v, e.volt);
      if (s !== e.sat) report_mismatch("saturated", {31'd0, s}, {31'd0, e.sat});
    endtask
  endclass

  motor_scoreboard sb = new();

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_applied_torque, out_drive_voltage, out_saturated);
  end

  // Receiver stall, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // One input transaction; entered and left at a falling edge.
  task automatic send_item(cmd_t c, logic [31:0] v, logic [31:0] a, logic [31:0] r,
                           logic [30:0] dt);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_command_value <= v;
    in_joint_angle <= a;
    in_joint_rate <= r;
    in_step_time <= dt;
    do @(posedge clk); while (in_stall);
    sb.note_input(c, v, a, r, dt);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes all eight registers while the unit is idle.
  task automatic apply_config(logic [31:0] k, logic [31:0] r, logic [31:0] n,
                              logic [31:0] e, logic [31:0] vs, logic [31:0] j,
                              logic [31:0] p, logic [31:0] d);
    logic [31:0] vals [8];
    vals = '{k, r, n, e, vs, j, p, d};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      sb.write_reg(reg_idx_t'(i), vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    if ($urandom_range(9) < 7) return 32'($signed($urandom_range(2097152)) - 1048576);
    return $urandom();
  endfunction

  function automatic logic [30:0] rand_step();
    if ($urandom_range(9) < 8) return 31'($urandom_range(6554));
    return 31'($urandom());
  endfunction

  function automatic logic [31:0] rand_reg(bit wide);
    if (wide) return $urandom();
    return $urandom_range(1 << 22);
  endfunction

  // Random transactions: mostly init, a drive command, then a run of steps.
  task automatic random_items(int count);
    int sent;
    logic [31:0] ang, rt;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) < 8) begin
        ang = rand_value();
        rt = rand_value();
        send_item(CMD_INIT, rand_value(), ang, rt, rand_step());
        send_item($urandom_range(1) ? CMD_VOLT : CMD_TORQUE, rand_value(), rand_value(),
                  rand_value(), rand_step());
        sent += 2;
        repeat ($urandom_range(8, 2)) begin
          ang = ang + 32'($signed($urandom_range(8192)) - 4096);
          rt = rt + 32'($signed($urandom_range(8192)) - 4096);
          send_item(CMD_STEP, rand_value(), ang, rt, rand_step());
          sent++;
        end
      end else begin
        send_item(cmd_t'($urandom_range(3)), $urandom(), $urandom(), $urandom(),
                  31'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin
    #40ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: field extremes and every command under reset registers
    send_item(CMD_VOLT, 32'h7FFFFFFF, 32'h0, 32'h0, 31'h0);
    send_item(CMD_STEP, 32'h0, 32'h7FFFFFFF, 32'h0, 31'h7FFFFFFF);
    send_item(CMD_VOLT, 32'h80000000, 32'h0, 32'h0, 31'h0);
    send_item(CMD_STEP, 32'h0, 32'h80000000, 32'h7FFFFFFF, 31'h1);
    send_item(CMD_STEP, 32'h0, 32'h0, 32'h80000000, 31'h0);
    send_item(CMD_TORQUE, 32'h7FFFFFFF, 32'h0, 32'h7FFFFFFF, 31'h0);
    send_item(CMD_TORQUE, 32'h80000000, 32'h0, 32'h80000000, 31'h0);
    send_item(CMD_TORQUE, 32'h0, 32'h0, 32'h0, 31'h0);
    send_item(CMD_VOLT, 32'h00030000, 32'h0, 32'h0, 31'h0);
    send_item(CMD_STEP, 32'h0, 32'h0, 32'h00010000, 31'h00000666);
    send_item(CMD_INIT, 32'h0, 32'h80000000, 32'h7FFFFFFF, 31'h0);
    drain();

    // Disc enabled: tracker overflow; zero torque constant divisor paths below
    apply_config(32'd650, 32'd622592, 32'd12648448, 32'd58982, 32'd891290, 32'd655,
                 32'd3276800, 32'd131072);
    send_item(CMD_INIT, 32'h0, 32'h00010000, 32'h0, 31'h0);
    send_item(CMD_STEP, 32'h0, 32'h00020000, 32'h00008000, 31'h00000666);
    send_item(CMD_STEP, 32'h0, 32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF);
    send_item(CMD_INIT, 32'h0, 32'h80000000, 32'h7FFFFFFF, 31'h0);
    send_item(CMD_STEP, 32'h0, 32'h7FFFFFFF, 32'h80000000, 31'h00010000);
    drain();
    // zero torque constant: torque command divides by zero
    apply_config(32'd0, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'h80000000, 32'd0);
    send_item(CMD_TORQUE, 32'h00010000, 32'h0, 32'h0, 31'h0);
    send_item(CMD_TORQUE, 32'h0, 32'h0, 32'h0, 31'h0);
    send_item(CMD_TORQUE, 32'h80000000, 32'h0, 32'h0, 31'h0);
    send_item(CMD_STEP, 32'h0, 32'h0, 32'h7FFFFFFF, 31'h0);
    drain();

    // Random phases, each with a register setting and an idle/stall pattern
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_config(32'd650, 32'd622592, 32'd12648448, 32'd65536, 32'd891290,
                        32'd655, 32'd3276800, 32'd131072);
        1: apply_config(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd65536,
                        32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        2: apply_config(32'd0, 32'd1, 32'd1, 32'd0, 32'd0, 32'd1, 32'h80000000,
                        32'h7FFFFFFF);
        default: apply_config(rand_reg(1'($urandom_range(1))),
                              rand_reg(1'($urandom_range(1))) | 1,
                              rand_reg(1'($urandom_range(1))), $urandom_range(65536),
                              rand_reg(1'($urandom_range(1))),
                              rand_reg(1'($urandom_range(1))),
                              rand_reg(1'($urandom_range(1))),
                              rand_reg(1'($urandom_range(1))));
      endcase
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 75; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 75; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      random_items(40);
      if (ph == 0) hold_req = 1'b1;
      random_items(230);
      idle_pct = 0;
      stall_pct = 0;
      drain();
    end

    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule

>>> files.f
hdl/dcsm_pkg.sv
hdl/dcsm_datapath.sv
hdl/dcsm_ctrl.sv
hdl/dc_servo_motor_model_step_unit.sv
sim/dc_servo_motor_model_step_unit_test.sv
